// File: src/rpr_pkg.sv
`default_nettype none

package rpr_pkg;

   // Filter geometry
   localparam int MAX_PHASES = 16;
   localparam int MAX_TAPS = 32;
   localparam int PHASE_W = $clog2(MAX_PHASES);
   localparam int TAP_W = $clog2(MAX_TAPS);
   localparam int ADDR_W = PHASE_W + TAP_W;
   localparam int TABLE_SIZE = MAX_PHASES * MAX_TAPS;

   // Item field widths
   localparam int SAMPLE_W = 16;
   localparam int COEF_W = 16;
   localparam int INDEX_W = 9;

   // Configuration register widths
   localparam int FACTOR_W = 5;
   localparam int TAPS_W = 6;
   localparam int GAIN_W = 16;
   localparam int CSR_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int OFFSET_W = 6;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INTERP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAPS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN = 2'd3;

   // Reset values
   localparam logic [FACTOR_W-1:0] INTERP_RESET = 5'd1;
   localparam logic [FACTOR_W-1:0] DECIM_RESET = 5'd1;
   localparam logic [TAPS_W-1:0] TAPS_RESET = 6'd32;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

   // Item opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_COEF = 1'b1;

   // Arithmetic widths: exact dot product, exact gain product, Q2.14 * Q4.12
   localparam int PROD_W = SAMPLE_W + COEF_W;
   localparam int ACC_W = PROD_W + TAP_W;
   localparam int GPROD_W = ACC_W + GAIN_W + 1;
   localparam int FRAC_SHIFT = 26;
   localparam int QUOT_W = GPROD_W - FRAC_SHIFT;
   localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

   // Sequencer to datapath controls
   typedef struct packed {
      logic                shift_en;
      logic [SAMPLE_W-1:0] sample;
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [COEF_W-1:0]   wr_data;
      logic                issue;
      logic                clear;
      logic [PHASE_W-1:0]  row;
      logic [TAP_W-1:0]    tap;
      logic                gain_en;
      logic                scale_en;
      logic [GAIN_W-1:0]   gain;
   } rpr_ctrl_type;

   // Datapath status
   typedef struct packed {
      logic                busy;
      logic [SAMPLE_W-1:0] result;
   } rpr_stat_type;

   // Factor of 0 acts as 1, above MAX_PHASES as MAX_PHASES
   function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] v);
      logic [FACTOR_W-1:0] r;
      r = v;
      if (v == '0) r = FACTOR_W'(1);
      else if (v > FACTOR_W'(MAX_PHASES)) r = FACTOR_W'(MAX_PHASES);
      return r;
   endfunction

   // Tap count of 0 acts as 1, above MAX_TAPS as MAX_TAPS
   function automatic logic [TAPS_W-1:0] clamp_taps(input logic [TAPS_W-1:0] v);
      logic [TAPS_W-1:0] r;
      r = v;
      if (v == '0) r = TAPS_W'(1);
      else if (v > TAPS_W'(MAX_TAPS)) r = TAPS_W'(MAX_TAPS);
      return r;
   endfunction

endpackage

`default_nettype wire

// File: src/rpr_if.sv
`default_nettype none

// Request channel: audio samples and coefficient writes
interface rpr_req_if;
   logic                                valid;
   logic                                ready;
   logic                                op;
   logic signed [rpr_pkg::SAMPLE_W-1:0] sample;
   logic [rpr_pkg::INDEX_W-1:0]         coef_index;
   logic signed [rpr_pkg::COEF_W-1:0]   coef_value;

   modport source (output valid, op, sample, coef_index, coef_value, input ready);
   modport sink (input valid, op, sample, coef_index, coef_value, output ready);
endinterface

// Response channel: resampled output samples
interface rpr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rpr_pkg::SAMPLE_W-1:0] out_sample;
   logic                                last_of_run;

   modport source (output valid, out_sample, last_of_run, input ready);
   modport sink (input valid, out_sample, last_of_run, output ready);
endinterface

`default_nettype wire

// File: src/rpr_mac.sv
`default_nettype none

module rpr_mac (
   input  logic                  clock,
   input  logic                  reset,
   input  rpr_pkg::rpr_ctrl_type ctrl,
   output rpr_pkg::rpr_stat_type stat
);
   import rpr_pkg::*;

   logic signed [SAMPLE_W-1:0] hist_ff [MAX_TAPS];
   logic [COEF_W-1:0]          coef_mem [TABLE_SIZE];
   logic signed [COEF_W-1:0]   coef_rd_ff;
   logic signed [SAMPLE_W-1:0] hist_rd_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_in;
   logic signed [GPROD_W-1:0]  gprod_ff;
   logic signed [GAIN_W:0]     gain_s;
   logic signed [QUOT_W-1:0]   quot;
   logic signed [QUOT_W-1:0]   quot_rnd;
   logic signed [SAMPLE_W-1:0] result_ff;
   logic signed [SAMPLE_W-1:0] result_in;
   logic                       round_up;
   logic                       v1_ff, v2_ff, clr1_ff, clr2_ff;

   // Tap history, newest at entry 0
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TAPS; i++) hist_ff[i] <= '0;
      end else if (ctrl.shift_en) begin
         for (int i = MAX_TAPS - 1; i > 0; i--) hist_ff[i] <= hist_ff[i-1];
         hist_ff[0] <= $signed(ctrl.sample);
      end
   end

   // Coefficient table, registered read alongside the history tap
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) coef_mem[ctrl.wr_addr] <= ctrl.wr_data;
      coef_rd_ff <= $signed(coef_mem[{ctrl.row, ctrl.tap}]);
      hist_rd_ff <= hist_ff[ctrl.tap];
   end

   // MAC pipeline valids; clear rides with the first product of a row
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         clr1_ff <= 1'b0;
         clr2_ff <= 1'b0;
      end else begin
         v1_ff <= ctrl.issue;
         v2_ff <= v1_ff;
         clr1_ff <= ctrl.issue && ctrl.clear;
         clr2_ff <= clr1_ff;
      end
   end

   // Accumulate exact products
   always_comb begin
      acc_in = acc_ff;
      if (v2_ff) acc_in = (clr2_ff ? ACC_W'(0) : acc_ff) + ACC_W'(prod_ff);
   end

   // Gain, truncation toward zero and saturation
   assign gain_s = $signed({1'b0, ctrl.gain});
   assign quot = $signed(gprod_ff[GPROD_W-1:FRAC_SHIFT]);
   assign round_up = gprod_ff[GPROD_W-1] && (|gprod_ff[FRAC_SHIFT-1:0]);
   assign quot_rnd = quot + $signed({{(QUOT_W-1){1'b0}}, round_up});

   always_comb begin
      result_in = quot_rnd[SAMPLE_W-1:0];
      if (quot_rnd > QUOT_W'(SAT_MAX)) result_in = SAT_MAX;
      else if (quot_rnd < QUOT_W'(SAT_MIN)) result_in = SAT_MIN;
   end

   always_ff @(posedge clock) begin
      prod_ff <= coef_rd_ff * hist_rd_ff;
      acc_ff <= acc_in;
      if (ctrl.gain_en) gprod_ff <= acc_ff * gain_s;
      if (ctrl.scale_en) result_ff <= result_in;
   end

   assign stat.busy = v1_ff || v2_ff;
   assign stat.result = result_ff;

endmodule

`default_nettype wire

// File: src/rational_polyphase_resampler_unit.sv
// Rational L/M polyphase resampler for signed 16-bit audio. A coefficient item (op 1)
// is written into the 512-entry table and the block is ready again the next cycle.
// A sample item shifts into the 32-tap history, has its phase reduced modulo L (which
// matters only after a lowered interp_factor) and then produces every output, 0 to 16,
// whose source index falls on it, each through one shared 16x16 multiply-accumulate
// unit: the MAC walks one tap per cycle over the taps in use and drains, then the gain
// multiply and saturation finish the output. An output waits in a register until
// taken; while it waits the next one is computed, and the block stalls only when a
// second output is ready. Configuration must be written through the csr_ port only
// while the block is idle; the block itself does not enforce this.
`default_nettype none

module rational_polyphase_resampler_unit (
   input  logic                            clock,
   input  logic                            reset,
   rpr_req_if.sink                         req_ch,
   rpr_rsp_if.source                       rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [rpr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rpr_pkg::CSR_W-1:0]       csr_wdata
);
   import rpr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_MAC,
      ST_DRAIN,
      ST_GAIN,
      ST_SCALE,
      ST_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [FACTOR_W-1:0]     interp_ff, decim_ff;
   logic [TAPS_W-1:0]       taps_ff;
   logic [GAIN_W-1:0]       gain_ff;
   logic [PHASE_W-1:0]      row_ff, row_in;
   logic [PHASE_W-1:0]      phase_ff, phase_in;
   logic [OFFSET_W-1:0]     offset_ff, offset_in;
   logic [TAPS_W-1:0]       k_ff, k_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]     rsp_sample_ff, rsp_sample_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [FACTOR_W-1:0]     l_eff, m_eff;
   logic [TAPS_W-1:0]       q_eff;
   logic                    req_take;
   logic [OFFSET_W:0]       next_off;
   logic                    run_last;
   logic [PHASE_W-1:0]      row_next;
   logic                    coef_ok;
   rpr_ctrl_type            ctrl;
   rpr_stat_type            stat;

   rpr_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         interp_ff <= INTERP_RESET;
         decim_ff <= DECIM_RESET;
         taps_ff <= TAPS_RESET;
         gain_ff <= GAIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_INTERP: interp_ff <= csr_wdata[FACTOR_W-1:0];
            CSR_DECIM:  decim_ff <= csr_wdata[FACTOR_W-1:0];
            CSR_TAPS:   taps_ff <= csr_wdata[TAPS_W-1:0];
            CSR_GAIN:   gain_ff <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign l_eff = clamp_factor(interp_ff);
   assign m_eff = clamp_factor(decim_ff);
   assign q_eff = clamp_taps(taps_ff);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take = req_ch.valid && req_ch.ready;
   assign coef_ok = ({1'b0, req_ch.coef_index} < (INDEX_W + 1)'(TABLE_SIZE));

   // Offset after this output; last of the run when it reaches L
   assign next_off = {1'b0, offset_ff} + (OFFSET_W + 1)'(m_eff);
   assign run_last = next_off >= (OFFSET_W + 1)'(l_eff);
   assign row_next = ((FACTOR_W)'(row_ff) + FACTOR_W'(1) == l_eff) ? '0 : row_ff + 1'b1;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      phase_in = phase_ff;
      offset_in = offset_ff;
      k_in = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in = rsp_last_ff;

      ctrl = '0;
      ctrl.sample = req_ch.sample;
      ctrl.wr_addr = ADDR_W'(req_ch.coef_index);
      ctrl.wr_data = req_ch.coef_value;
      ctrl.row = row_ff;
      ctrl.tap = k_ff[TAP_W-1:0];
      ctrl.gain = gain_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_ch.op == OP_COEF) begin
                  ctrl.wr_en = coef_ok;
               end else begin
                  ctrl.shift_en = 1'b1;
                  row_in = phase_ff;
                  state_in = ST_REDUCE;
               end
            end
         end
         // row = phase mod L by repeated subtraction
         ST_REDUCE: begin
            if (FACTOR_W'(row_ff) >= l_eff) begin
               row_in = PHASE_W'(FACTOR_W'(row_ff) - l_eff);
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (offset_ff < OFFSET_W'(l_eff)) begin
               k_in = '0;
               state_in = ST_MAC;
            end else begin
               offset_in = offset_ff - OFFSET_W'(l_eff);
               state_in = ST_IDLE;
            end
         end
         // one tap per cycle into the MAC pipeline
         ST_MAC: begin
            ctrl.issue = 1'b1;
            ctrl.clear = (k_ff == '0);
            k_in = k_ff + 1'b1;
            if (k_ff + 1'b1 == q_eff) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!stat.busy) state_in = ST_GAIN;
         end
         ST_GAIN: begin
            ctrl.gain_en = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            ctrl.scale_en = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sample_in = stat.result;
               rsp_last_in = run_last;
               row_in = row_next;
               phase_in = row_next;
               if (run_last) begin
                  offset_in = OFFSET_W'(next_off - (OFFSET_W + 1)'(l_eff));
                  state_in = ST_IDLE;
               end else begin
                  offset_in = next_off[OFFSET_W-1:0];
                  k_in = '0;
                  state_in = ST_MAC;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= '0;
         offset_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         offset_ff <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff <= row_in;
      k_ff <= k_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.out_sample = $signed(rsp_sample_ff);
   assign rsp_ch.last_of_run = rsp_last_ff;

endmodule

`default_nettype wire

// File: src/rpr_checker.sv
`default_nettype none

module rpr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_op,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rpr_pkg::SAMPLE_W-1:0]  rsp_out_sample,
   input logic                          rsp_last
);
   import rpr_pkg::*;

   // Reset leaves the block idle with no pending output
   a_reset_idle: assert property (@(posedge clock) reset |=> (req_ready && !rsp_valid))
      else $error("block not idle after reset");

   // After a coefficient write the block is ready again in the next cycle
   a_coef_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == OP_COEF) |=> req_ready)
      else $error("not ready after coefficient write");

   // A sample item keeps the block busy
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == OP_SAMPLE) |=> !req_ready)
      else $error("ready right after sample item");

   // Stalled output holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_out_sample) && $stable(rsp_last)))
      else $error("stalled output changed");

endmodule

bind rational_polyphase_resampler_unit rpr_checker u_rpr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_op         (req_ch.op),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_out_sample (rsp_ch.out_sample),
   .rsp_last       (rsp_ch.last_of_run)
);

`default_nettype wire
